/* sv/dda_pkg.sv */
package dda_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;         // latch endpoints, differences and step count
        logic div_step;     // one restoring division step on both axes
        logic div_shift;    // shift the partial remainder before the step
        logic emit_start;   // set increments, emit the start pixel
        logic advance;      // step both accumulators, emit a pixel
        logic idle_result;  // emit an empty result
    } dda_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic active;
    } dda_stat_t;

endpackage

/* sv/dda_req_if.sv */
interface dda_req_if #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, op, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, op, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

/* sv/dda_pix_if.sv */
interface dda_pix_if #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         pixel_valid;
    logic                         last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_valid, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_valid, last_pixel,
        output ready
    );
endinterface

/* sv/dda_ctrl.sv */
module dda_ctrl #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_op,
    output logic              req_ready,
    output logic              pix_valid,
    input  logic              pix_ready,
    output dda_pkg::dda_cmd_t cmd,
    input  dda_pkg::dda_stat_t stat
);
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

    typedef enum logic [2:0] {
        S_READY = 3'b001,
        S_DIV   = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;
    logic             accept;
    logic             out_load;

    assign slot_free = !out_valid_reg || pix_ready;
    assign req_ready = (state_reg == S_READY) && slot_free;
    assign accept    = req_valid && req_ready;
    assign pix_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_READY:
            begin
                if (accept)
                begin
                    if (req_op == dda_pkg::OP_START)
                    begin
                        cmd.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                    else if (stat.active)
                    begin
                        cmd.advance = 1'b1;
                        out_load    = 1'b1;
                    end
                    else
                    begin
                        cmd.idle_result = 1'b1;
                        out_load        = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_shift = (cnt_reg != '0);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit_start = 1'b1;
                    out_load       = 1'b1;
                    state_next     = S_READY;
                end
            end
            default:
            begin
                state_next = S_READY;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (pix_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_READY;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_cnt_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 |-> state_reg == S_DIV)
        else $error("division counter running outside division");

    a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_op == dda_pkg::OP_START |=> state_reg == S_DIV)
        else $error("start request did not enter division");

    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && slot_free |=> out_valid_reg && state_reg == S_READY)
        else $error("start pixel not emitted");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_READY |-> !req_ready)
        else $error("request taken while dividing");
endmodule

/* sv/dda_dp.sv */
module dda_dp #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dda_pkg::dda_cmd_t            cmd,
    output dda_pkg::dda_stat_t           stat,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         pixel_valid,
    output logic                         last_pixel
);
    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int AW  = C + F + 1;   // accumulator
    localparam int IW  = F + 2;       // increment
    localparam int DFW = C + 1;       // endpoint difference
    localparam int SW  = C;           // step count, |difference|
    localparam int RW  = C + 1;       // partial remainder
    localparam int QW  = F + 1;       // quotient magnitude
    localparam logic [AW-1:0] HALF = AW'(1) << (F - 1);

    function automatic logic [C-1:0] round_pix(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] t;
        logic signed [AW-1:0] sh;
        logic [C-1:0]         r;
        t  = a + $signed(HALF);
        sh = t >>> F;
        r  = sh[C-1:0];
        // floor of a negative sum with a fraction is one below toward-zero
        if (t[AW-1] && (t[F-1:0] != '0))
            r = r + C'(1);
        return r;
    endfunction

    logic signed [AW-1:0] acc_x_reg, acc_y_reg;
    logic signed [IW-1:0] inc_x_reg, inc_y_reg;
    logic [SW-1:0]        steps_reg;
    logic [SW-1:0]        steps_left_reg;
    logic                 active_reg;
    logic [RW-1:0]        rem_x_reg, rem_y_reg;
    logic [QW-1:0]        q_x_reg, q_y_reg;
    logic                 neg_x_reg, neg_y_reg;
    logic [C-1:0]         pix_x_reg, pix_y_reg;
    logic                 pix_valid_reg, last_reg;

    logic signed [DFW-1:0] x0_ext, y0_ext, dx, dy, dx_abs, dy_abs;
    logic [SW-1:0]         ax, ay, steps_new;
    logic [RW-1:0]         div_s, rx_sh, ry_sh, rx_next, ry_next;
    logic                  gex, gey;
    logic signed [IW-1:0]  qx_ext, qy_ext, inc_x_new, inc_y_new;
    logic signed [AW-1:0]  acc_x_sum, acc_y_sum, acc_x_pix, acc_y_pix;

    // endpoint differences and step count
    assign x0_ext    = DFW'(start_x);
    assign y0_ext    = DFW'(start_y);
    assign dx        = DFW'(end_x) - x0_ext;
    assign dy        = DFW'(end_y) - y0_ext;
    assign dx_abs    = dx[DFW-1] ? -dx : dx;
    assign dy_abs    = dy[DFW-1] ? -dy : dy;
    assign ax        = dx_abs[SW-1:0];
    assign ay        = dy_abs[SW-1:0];
    assign steps_new = (ax > ay) ? ax : ay;

    // restoring division, one quotient bit per axis per cycle
    assign div_s   = {1'b0, steps_reg};
    assign rx_sh   = cmd.div_shift ? {rem_x_reg[RW-2:0], 1'b0} : rem_x_reg;
    assign ry_sh   = cmd.div_shift ? {rem_y_reg[RW-2:0], 1'b0} : rem_y_reg;
    assign gex     = rx_sh >= div_s;
    assign gey     = ry_sh >= div_s;
    assign rx_next = gex ? rx_sh - div_s : rx_sh;
    assign ry_next = gey ? ry_sh - div_s : ry_sh;

    assign qx_ext    = $signed({1'b0, q_x_reg});
    assign qy_ext    = $signed({1'b0, q_y_reg});
    assign inc_x_new = (steps_reg == '0) ? '0 : (neg_x_reg ? -qx_ext : qx_ext);
    assign inc_y_new = (steps_reg == '0) ? '0 : (neg_y_reg ? -qy_ext : qy_ext);

    assign acc_x_sum = acc_x_reg + {{(AW-IW){inc_x_reg[IW-1]}}, inc_x_reg};
    assign acc_y_sum = acc_y_reg + {{(AW-IW){inc_y_reg[IW-1]}}, inc_y_reg};
    assign acc_x_pix = cmd.advance ? acc_x_sum : acc_x_reg;
    assign acc_y_pix = cmd.advance ? acc_y_sum : acc_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            steps_left_reg <= '0;
        end
        else if (cmd.emit_start)
        begin
            active_reg     <= (steps_reg != '0);
            steps_left_reg <= steps_reg;
        end
        else if (cmd.advance)
        begin
            active_reg     <= (steps_left_reg != SW'(1));
            steps_left_reg <= steps_left_reg - SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_x_reg <= {x0_ext, {F{1'b0}}};
            acc_y_reg <= {y0_ext, {F{1'b0}}};
            steps_reg <= steps_new;
            rem_x_reg <= {1'b0, ax};
            rem_y_reg <= {1'b0, ay};
            q_x_reg   <= '0;
            q_y_reg   <= '0;
            neg_x_reg <= dx[DFW-1];
            neg_y_reg <= dy[DFW-1];
        end
        if (cmd.div_step)
        begin
            rem_x_reg <= rx_next;
            rem_y_reg <= ry_next;
            q_x_reg   <= {q_x_reg[QW-2:0], gex};
            q_y_reg   <= {q_y_reg[QW-2:0], gey};
        end
        if (cmd.emit_start)
        begin
            inc_x_reg <= inc_x_new;
            inc_y_reg <= inc_y_new;
        end
        if (cmd.advance)
        begin
            acc_x_reg <= acc_x_sum;
            acc_y_reg <= acc_y_sum;
        end
        if (cmd.emit_start || cmd.advance)
        begin
            pix_x_reg     <= round_pix(acc_x_pix);
            pix_y_reg     <= round_pix(acc_y_pix);
            pix_valid_reg <= 1'b1;
            last_reg      <= cmd.emit_start ? (steps_reg == '0)
                                            : (steps_left_reg == SW'(1));
        end
        else if (cmd.idle_result)
        begin
            pix_x_reg     <= '0;
            pix_y_reg     <= '0;
            pix_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
    end

    assign stat.active  = active_reg;
    assign pixel_x      = $signed(pix_x_reg);
    assign pixel_y      = $signed(pix_y_reg);
    assign pixel_valid  = pix_valid_reg;
    assign last_pixel   = last_reg;
endmodule

/* sv/dda_line_rasterizer.sv */
// Start request: endpoints are latched on acceptance, then FRAC_BITS+1 restoring
// division steps run and the start pixel is emitted once the output slot is free.
// No request is taken while the division runs.
// Advance request: one per cycle while the output is not stalled, result presented the cycle after acceptance.
// Reset (rst_n low, asynchronous) leaves the block idle with no result pending.
module dda_line_rasterizer #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    dda_req_if.sink  req,
    dda_pix_if.source pix
);
    dda_pkg::dda_cmd_t  cmd;
    dda_pkg::dda_stat_t stat;

    dda_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .pix_valid (pix.valid),
        .pix_ready (pix.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    dda_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .start_x     (req.start_x),
        .start_y     (req.start_y),
        .end_x       (req.end_x),
        .end_y       (req.end_y),
        .pixel_x     (pix.pixel_x),
        .pixel_y     (pix.pixel_y),
        .pixel_valid (pix.pixel_valid),
        .last_pixel  (pix.last_pixel)
    );
endmodule
